// ===== design/grle_pkg.sv =====
package grle_pkg;

   // Default display geometry in pixels.
   localparam int DefDisplayWidth  = 212;
   localparam int DefDisplayHeight = 64;

   // Command codes.
   localparam logic [2:0] OP_POINT = 3'd0;
   localparam logic [2:0] OP_HLINE = 3'd1;
   localparam logic [2:0] OP_VLINE = 3'd2;
   localparam logic [2:0] OP_BAND  = 3'd3;
   localparam logic [2:0] OP_READ  = 3'd4;

   // Draw modes; the unused code acts as xor.
   localparam logic [1:0] MODE_XOR   = 2'd0;
   localparam logic [1:0] MODE_SET   = 2'd1;
   localparam logic [1:0] MODE_ERASE = 2'd2;

   localparam logic [7:0] DOTTED_PATTERN = 8'h55;
   localparam logic [7:0] LOW_NIBBLE     = 8'h0F;
   localparam logic [7:0] HIGH_NIBBLE    = 8'hF0;
   localparam logic [7:0] ALL_ONES       = 8'hFF;
   localparam logic [7:0] PATTERN_FILL   = 8'h80;

   // Sequencer states.
   typedef enum logic [7:0] {
      ST_CLEAR = 8'b0000_0001,
      ST_IDLE  = 8'b0000_0010,
      ST_SETUP = 8'b0000_0100,
      ST_STEP  = 8'b0000_1000,
      ST_READ  = 8'b0001_0000,
      ST_WAIT  = 8'b0010_0000,
      ST_WRITE = 8'b0100_0000,
      ST_DONE  = 8'b1000_0000
   } state_type;

endpackage

// ===== design/greyscale_raster_line_engine.sv =====
// Greyscale raster line engine: a 4-bit frame store, two pixel rows per byte.
// The req_ channel carries one command per beat (point, horizontal line,
// vertical line, text band invert or byte read); the rsp_ channel returns
// exactly one beat per command holding the read byte and a reject flag.
// Each command is handled by one sequencer that walks pixels one at a time
// through a single read-modify-write on the frame store RAM: a drawn pixel or
// band byte passes through the address, read, registered data and write steps,
// and a pixel skipped by the pattern passes through the address step alone.
// req_tready is high only when the sequencer is idle and the response
// register is empty or being drained. A stalled receiver holds the response
// in the output register; the next command is not taken until it drains.
// After reset the block clears all DISPLAY_WIDTH * ((DISPLAY_HEIGHT + 7) / 8) * 4
// bytes of the frame store, one byte a cycle, before it accepts
// its first command.
module greyscale_raster_line_engine
   import grle_pkg::*;
#(
   parameter int DISPLAY_WIDTH  = DefDisplayWidth,
   parameter int DISPLAY_HEIGHT = DefDisplayHeight
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // Low to high: operation[2:0], x_coord[12:3], y_coord[22:13],
   // line_length[32:23], pattern[40:33], grey_level[44:41], draw_mode[46:45],
   // white_trim[47], band_index[55:48], read_address[68:56], zero fill.
   input  logic [71:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // Low to high: read_data[7:0], rejected[8], zero fill.
   output logic [15:0] rsp_tdata
);

   localparam int StoreSize = DISPLAY_WIDTH * ((DISPLAY_HEIGHT + 7) / 8) * 4;
   localparam int AddrW     = $clog2(StoreSize);
   localparam int BandBytes = 4 * DISPLAY_WIDTH;
   localparam int NumBands  = DISPLAY_HEIGHT / 8;
   localparam int CntW      = $clog2(BandBytes + 1);

   // Unpacked command fields.
   logic [2:0]         op_in;
   logic signed [9:0]  x_in, y_in, len_in;
   logic signed [7:0]  band_in;
   logic [12:0]        raddr_in;
   assign op_in    = req_tdata[2:0];
   assign x_in     = req_tdata[12:3];
   assign y_in     = req_tdata[22:13];
   assign len_in   = req_tdata[32:23];
   assign band_in  = req_tdata[55:48];
   assign raddr_in = req_tdata[68:56];

   state_type          state_ff, state_in;
   logic [2:0]         op_ff, op_in_r;
   logic signed [11:0] x_ff, x_in_r, y_ff, y_in_r;
   logic signed [11:0] len_ff, len_in_r;
   logic [7:0]         pat_ff, pat_in;
   logic [3:0]         grey_ff, grey_in;
   logic [1:0]         mode_ff, mode_in;
   logic               white_ff, white_in;
   logic signed [7:0]  band_ff, band_in_r;
   logic [12:0]        raddr_ff, raddr_in_r;
   logic [CntW-1:0]    cnt_ff, cnt_in;
   logic [AddrW-1:0]   addr_ff, addr_in;
   logic [7:0]         mask_ff, mask_in;
   logic               rej_ff, rej_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_data_ff, rsp_data_in;
   logic               rsp_rej_ff, rsp_rej_in;

   logic               wr_en;
   logic [AddrW-1:0]   wr_addr, rd_addr;
   logic [7:0]         wr_data, rd_data;

   logic               accept, rsp_free;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && rsp_free;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_rej_ff, rsp_data_ff};

   grle_ram #(.Width(8), .Depth(StoreSize)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Mask modification of the fetched byte.
   logic [7:0] m_eff, new_byte;
   always_comb begin
      m_eff = mask_ff;
      if (white_ff) begin
         if ((rd_data & LOW_NIBBLE) != 8'd0) m_eff = m_eff & HIGH_NIBBLE;
         if ((rd_data & HIGH_NIBBLE) != 8'd0) m_eff = m_eff & LOW_NIBBLE;
      end
      if (op_ff == OP_BAND) begin
         new_byte = rd_data ^ ALL_ONES;
      end else if (mode_ff == MODE_SET) begin
         new_byte = rd_data | m_eff;
      end else if (mode_ff == MODE_ERASE) begin
         new_byte = rd_data & ~m_eff;
      end else begin
         new_byte = rd_data ^ m_eff;
      end
   end

   // Setup arithmetic: clipping of line start and length.
   logic signed [11:0] s_start, s_len, s_end, c_start, c_len;
   logic signed [11:0] lim;
   logic               in_fixed;
   always_comb begin
      s_start = (op_ff == OP_HLINE) ? x_ff : y_ff;
      s_len   = len_ff;
      lim     = (op_ff == OP_HLINE) ? 12'(DISPLAY_WIDTH) : 12'(DISPLAY_HEIGHT);
      in_fixed = (op_ff == OP_HLINE) ?
                 (y_ff >= 0 && y_ff < 12'(DISPLAY_HEIGHT)) :
                 (x_ff >= 0 && x_ff < 12'(DISPLAY_WIDTH));
      if (s_len < 0) begin
         s_start = s_start + s_len + 12'sd1;
         s_len   = -s_len;
      end
      s_end   = s_start + s_len;
      c_start = (s_start < 0) ? 12'sd0 : s_start;
      c_len   = ((s_end > lim) ? lim : s_end) - c_start;
   end

   // Next pattern after one pixel.
   logic [7:0] pat_shift;
   assign pat_shift = pat_ff[0] ? ((pat_ff >> 1) | PATTERN_FILL) : (pat_ff >> 1);

   always_comb begin
      state_in    = state_ff;
      op_in_r     = op_ff;
      x_in_r      = x_ff;
      y_in_r      = y_ff;
      len_in_r    = len_ff;
      pat_in      = pat_ff;
      grey_in     = grey_ff;
      mode_in     = mode_ff;
      white_in    = white_ff;
      band_in_r   = band_ff;
      raddr_in_r  = raddr_ff;
      cnt_in      = cnt_ff;
      addr_in     = addr_ff;
      mask_in     = mask_ff;
      rej_in      = rej_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      rsp_rej_in  = rsp_rej_ff;
      wr_en       = 1'b0;
      wr_addr     = addr_ff;
      wr_data     = new_byte;
      rd_addr     = addr_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            // Zero the store one byte a cycle.
            wr_en   = 1'b1;
            wr_data = 8'd0;
            addr_in = addr_ff + AddrW'(1);
            if (addr_ff == AddrW'(StoreSize - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               op_in_r    = op_in;
               x_in_r     = 12'(x_in);
               y_in_r     = 12'(y_in);
               len_in_r   = 12'(len_in);
               pat_in     = req_tdata[40:33];
               grey_in    = req_tdata[44:41];
               mode_in    = req_tdata[46:45];
               white_in   = req_tdata[47];
               band_in_r  = band_in;
               raddr_in_r = raddr_in;
               state_in   = ST_SETUP;
            end
         end
         ST_SETUP: begin
            rej_in   = 1'b1;
            state_in = ST_DONE;
            rsp_data_in = 8'd0;
            unique case (op_ff)
               OP_POINT: begin
                  if (x_ff >= 0 && x_ff < 12'(DISPLAY_WIDTH) &&
                      y_ff >= 0 && y_ff < 12'(DISPLAY_HEIGHT)) begin
                     rej_in   = 1'b0;
                     cnt_in   = CntW'(1);
                     state_in = ST_STEP;
                  end
               end
               OP_HLINE, OP_VLINE: begin
                  if (in_fixed && len_ff != 0 && s_end > 0 && s_start < lim) begin
                     rej_in   = 1'b0;
                     cnt_in   = CntW'(c_len);
                     state_in = ST_STEP;
                     if (op_ff == OP_HLINE) begin
                        x_in_r = c_start;
                     end else begin
                        y_in_r = c_start;
                        if (pat_ff == DOTTED_PATTERN && !c_start[0]) begin
                           pat_in = ~pat_ff;
                        end
                     end
                  end
               end
               OP_BAND: begin
                  if (band_ff >= 0 && band_ff < 8'(NumBands)) begin
                     rej_in   = 1'b0;
                     cnt_in   = CntW'(BandBytes);
                     state_in = ST_STEP;
                  end
               end
               OP_READ: begin
                  if (raddr_ff < 13'(StoreSize)) begin
                     rej_in   = 1'b0;
                     addr_in  = AddrW'(raddr_ff);
                     state_in = ST_READ;
                  end
               end
               default: begin
               end
            endcase
            // A band walks from its first byte; a vertical line from its clipped row.
            if (op_ff == OP_BAND) begin
               x_in_r = 12'sd0;
               y_in_r = 12'(band_ff) <<< 3;
            end else if (op_ff == OP_VLINE) begin
               y_in_r = (state_in == ST_STEP) ? c_start : y_ff;
            end
         end
         ST_STEP: begin
            // Visit the next pixel or byte, or finish when the count runs out.
            if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               addr_in  = (op_ff == OP_BAND) ?
                          AddrW'(32'(band_ff) * BandBytes) + AddrW'(BandBytes) -
                          AddrW'(cnt_ff) :
                          AddrW'(32'(y_ff >>> 1) * DISPLAY_WIDTH) + AddrW'(x_ff);
               mask_in  = y_ff[0] ? {~grey_ff, 4'd0} : {4'd0, ~grey_ff};
               if (op_ff == OP_BAND || op_ff == OP_POINT || pat_ff[0]) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_STEP;
                  pat_in   = pat_shift;
                  cnt_in   = cnt_ff - CntW'(1);
                  if (op_ff == OP_HLINE) x_in_r = x_ff + 12'sd1;
                  else y_in_r = y_ff + 12'sd1;
               end
            end
         end
         ST_READ: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (op_ff == OP_READ) begin
               rsp_data_in = rd_data;
               state_in    = ST_DONE;
            end else begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            wr_en    = 1'b1;
            state_in = ST_STEP;
            cnt_in   = cnt_ff - CntW'(1);
            pat_in   = pat_shift;
            if (op_ff == OP_HLINE) x_in_r = x_ff + 12'sd1;
            else if (op_ff == OP_VLINE) y_in_r = y_ff + 12'sd1;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_rej_in   = rej_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         addr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in_r;
      x_ff        <= x_in_r;
      y_ff        <= y_in_r;
      len_ff      <= len_in_r;
      pat_ff      <= pat_in;
      grey_ff     <= grey_in;
      mode_ff     <= mode_in;
      white_ff    <= white_in;
      band_ff     <= band_in_r;
      raddr_ff    <= raddr_in_r;
      cnt_ff      <= cnt_in;
      mask_ff     <= mask_in;
      rej_ff      <= rej_in;
      rsp_data_ff <= rsp_data_in;
      rsp_rej_ff  <= rsp_rej_in;
   end

endmodule

// ===== design/grle_ram.sv =====
module grle_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== design/grle_checker.sv =====
module grle_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // A stalled response beat keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // A command is never taken in the cycle after another one.
   a_one_at_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("command accepted back to back");

   // Fill bits of the response are always zero.
   a_rsp_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15:9] == 7'd0)
      else $error("response fill bits set");

   // No response appears right after an accepted command.
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)
      else $error("response too early");

endmodule

bind greyscale_raster_line_engine grle_checker u_grle_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
